FILE: rtl/nnr_pkg.sv
package nnr_pkg;

    // width of the radicand, the root and every internal iterate
    localparam int W = 48;

    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};

    localparam int CFG_ADDR_W = 5;

    typedef enum logic [1:0] {
        REG_SQRT_ITER = 2'd0,
        REG_ROOT_ITER = 2'd1,
        REG_SQRT_SEED = 2'd2,
        REG_ROOT_SEED = 2'd3
    } reg_idx_t;

    // status of a shared serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

FILE: rtl/nnr_mul.sv
module nnr_mul (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [nnr_pkg::W-1:0]        a,
    input  logic [nnr_pkg::W-1:0]        b,
    output logic [2*nnr_pkg::W-1:0]      prod,
    output nnr_pkg::unit_stat_t          stat
);

    localparam int W  = nnr_pkg::W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]   a_reg;
    logic [2*W-1:0] prod_reg, prod_next;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [W:0]     upper_sum;

    // one multiplier bit a cycle, lsb first; the product shifts in from the top
    always_comb begin
        upper_sum = {1'b0, prod_reg[2*W-1:W]} + (prod_reg[0] ? {1'b0, a_reg} : '0);
        prod_next = {upper_sum, prod_reg[W-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
                a_reg    <= a;
                prod_reg <= {{W{1'b0}}, b};
            end else if (busy_reg) begin
                prod_reg <= prod_next;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign prod      = prod_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/nnr_div.sv
module nnr_div #(
    parameter int DW = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [DW-1:0]          dividend,
    input  logic [nnr_pkg::W-1:0]  divisor,
    output logic [DW-1:0]          quotient,
    output nnr_pkg::unit_stat_t    stat
);

    localparam int W  = nnr_pkg::W;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] dq_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic          ge;

    // restoring division, one quotient bit a cycle; quotient bits replace dividend bits
    always_comb begin
        rem_sh = {rem_reg, dq_reg[DW-1]};
        diff   = rem_sh - {1'b0, den_reg};
        ge     = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
                dq_reg   <= dividend;
                rem_reg  <= '0;
                den_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[W-1:0] : rem_sh[W-1:0];
                dq_reg  <= {dq_reg[DW-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = dq_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/newton_nth_root.sv
// Error, degree one and zero radicand go straight to S_FIN, which registers the result once
// the output register is free. Square root: sqrt_iterations steps x = (x + mag/x)/2, each one
// serial divide. Degree n: root_iterations steps, each n-1 multiplies for x^(n-1), a divide,
// a multiply by n-1 and a divide by n, the shared serial units running one at a time.
// Throughput: one word in flight; the next is taken the cycle after the result is registered.
// Reset (aresetn low, synchronous) restores the default registers and empties the block.
module newton_nth_root #(
    parameter int MAX_DEGREE    = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // radicand[47:0]
    input  logic [4:0]  s_tuser,   // degree[4:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // root_value[47:0]
    output logic [1:0]  m_tuser,   // imaginary[0], error[1]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [nnr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int W  = nnr_pkg::W;
    localparam int F  = FRACTION_BITS;
    localparam int DW = W + F;

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_POW, S_QUO, S_SCALE, S_AVG, S_FIN
    } state_t;

    state_t        state_reg;
    logic          issued_reg;
    logic [7:0]    sqrt_iter_reg, root_iter_reg;
    logic [W-2:0]  sqrt_seed_reg, root_seed_reg;
    logic [7:0]    iter_reg;
    logic [W-1:0]  mag_reg, x_reg, p_reg, q_reg, val_reg;
    logic [DW-1:0] t_reg;
    logic [4:0]    n_reg, k_reg;
    logic          imag_reg, err_reg;
    logic          m_tvalid_reg;
    logic [W-1:0]  m_data_reg;
    logic [1:0]    m_user_reg;

    logic                 mul_start, div_start;
    logic [W-1:0]         mul_a, mul_b;
    logic [2*W-1:0]       mul_prod;
    logic [DW-1:0]        div_num, div_q;
    logic [W-1:0]         div_den;
    nnr_pkg::unit_stat_t  mul_stat, div_stat;
    logic [W-1:0]         mul_sat, div_sat;
    logic [W:0]           sq_sum;

    logic          in_acc;
    logic          in_neg;
    logic [W-1:0]  in_mag;
    logic          deg_bad;
    logic          cfg_wr;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_neg   = s_tdata[W-1];
    assign in_mag   = in_neg ? (~s_tdata + 1'b1) : s_tdata;
    assign deg_bad  = (s_tuser == 5'd0) || (32'(s_tuser) > MAX_DEGREE);
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign pready = 1'b1;

    always_comb begin
        unique case (nnr_pkg::reg_idx_t'(paddr[4:3]))
            nnr_pkg::REG_SQRT_ITER: prdata = {56'd0, sqrt_iter_reg};
            nnr_pkg::REG_ROOT_ITER: prdata = {56'd0, root_iter_reg};
            nnr_pkg::REG_SQRT_SEED: prdata = {17'd0, sqrt_seed_reg};
            nnr_pkg::REG_ROOT_SEED: prdata = {17'd0, root_seed_reg};
            default:                prdata = '0;
        endcase
    end

    // operand selection for the shared units
    always_comb begin
        if (state_reg == S_SCALE) begin
            mul_a = x_reg;
            mul_b = W'(n_reg - 5'd1);
        end else begin
            mul_a = p_reg;
            mul_b = x_reg;
        end
        unique case (state_reg)
            S_SQ:    begin div_num = {mag_reg, {F{1'b0}}}; div_den = x_reg; end
            S_QUO:   begin div_num = {mag_reg, {F{1'b0}}}; div_den = p_reg; end
            S_AVG:   begin div_num = t_reg + DW'(q_reg);   div_den = W'(n_reg); end
            default: begin div_num = {mag_reg, {F{1'b0}}}; div_den = x_reg; end
        endcase
        mul_start = !issued_reg && (state_reg == S_SCALE ||
                                    (state_reg == S_POW && k_reg < n_reg));
        div_start = !issued_reg && (state_reg == S_SQ || state_reg == S_QUO ||
                                    state_reg == S_AVG);
        mul_sat = (|mul_prod[2*W-1:F+W-1]) ? nnr_pkg::SAT_MAX
                                           : {1'b0, mul_prod[F+W-2:F]};
        div_sat = (|div_q[DW-1:W-1]) ? nnr_pkg::SAT_MAX : {1'b0, div_q[W-2:0]};
        sq_sum  = {1'b0, x_reg} + {1'b0, div_sat};
    end

    nnr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .prod    (mul_prod),
        .stat    (mul_stat)
    );

    nnr_div #(.DW(DW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_q),
        .stat     (div_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            sqrt_iter_reg <= 8'd10;
            root_iter_reg <= 8'd50;
            sqrt_seed_reg <= (W-1)'(3276800);
            root_seed_reg <= (W-1)'(655360);
        end else begin
            if (cfg_wr) begin
                unique case (nnr_pkg::reg_idx_t'(paddr[4:3]))
                    nnr_pkg::REG_SQRT_ITER: sqrt_iter_reg <= pwdata[7:0];
                    nnr_pkg::REG_ROOT_ITER: root_iter_reg <= pwdata[7:0];
                    nnr_pkg::REG_SQRT_SEED: sqrt_seed_reg <= pwdata[W-2:0];
                    nnr_pkg::REG_ROOT_SEED: root_seed_reg <= pwdata[W-2:0];
                    default: ;
                endcase
            end

            // in S_FIN the output register is reloaded below
            if (m_tvalid_reg && m_tready && state_reg != S_FIN) begin
                m_tvalid_reg <= 1'b0;
            end

            if (mul_start || div_start) begin
                issued_reg <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        mag_reg  <= in_mag;
                        n_reg    <= s_tuser;
                        p_reg    <= W'(1) << F;
                        k_reg    <= 5'd1;
                        if (deg_bad) begin
                            imag_reg  <= 1'b0;
                            err_reg   <= 1'b1;
                            val_reg   <= '0;
                            state_reg <= S_FIN;
                        end else if (s_tuser == 5'd1) begin
                            imag_reg  <= 1'b0;
                            err_reg   <= 1'b0;
                            val_reg   <= s_tdata;
                            state_reg <= S_FIN;
                        end else if (s_tdata == '0) begin
                            imag_reg  <= 1'b0;
                            err_reg   <= 1'b0;
                            val_reg   <= '0;
                            state_reg <= S_FIN;
                        end else if (s_tuser == 5'd2) begin
                            imag_reg <= in_neg;
                            err_reg  <= 1'b0;
                            x_reg    <= {1'b0, sqrt_seed_reg};
                            val_reg  <= {1'b0, sqrt_seed_reg};
                            iter_reg <= sqrt_iter_reg;
                            state_reg <= (sqrt_iter_reg == 8'd0) ? S_FIN : S_SQ;
                        end else if (in_neg) begin
                            imag_reg  <= 1'b0;
                            err_reg   <= 1'b1;
                            val_reg   <= '0;
                            state_reg <= S_FIN;
                        end else begin
                            imag_reg <= 1'b0;
                            err_reg  <= 1'b0;
                            x_reg    <= {1'b0, root_seed_reg};
                            val_reg  <= {1'b0, root_seed_reg};
                            iter_reg <= root_iter_reg;
                            state_reg <= (root_iter_reg == 8'd0) ? S_FIN : S_POW;
                        end
                    end
                end
                S_SQ: begin
                    if (div_stat.done) begin
                        issued_reg <= 1'b0;
                        x_reg      <= sq_sum[W:1];
                        val_reg    <= sq_sum[W:1];
                        iter_reg   <= iter_reg - 8'd1;
                        if (iter_reg == 8'd1) begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_POW: begin
                    // build x^(n-1) one multiply at a time
                    if (!issued_reg && !(k_reg < n_reg)) begin
                        state_reg <= S_QUO;
                    end else if (mul_stat.done) begin
                        issued_reg <= 1'b0;
                        p_reg      <= mul_sat;
                        k_reg      <= k_reg + 5'd1;
                    end
                end
                S_QUO: begin
                    if (div_stat.done) begin
                        issued_reg <= 1'b0;
                        q_reg      <= div_sat;
                        state_reg  <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (mul_stat.done) begin
                        issued_reg <= 1'b0;
                        t_reg      <= mul_prod[DW-1:0];
                        state_reg  <= S_AVG;
                    end
                end
                S_AVG: begin
                    if (div_stat.done) begin
                        issued_reg <= 1'b0;
                        x_reg      <= div_sat;
                        val_reg    <= div_sat;
                        p_reg      <= W'(1) << F;
                        k_reg      <= 5'd1;
                        iter_reg   <= iter_reg - 8'd1;
                        state_reg  <= (iter_reg == 8'd1) ? S_FIN : S_POW;
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_data_reg   <= val_reg;
                        m_user_reg   <= {err_reg, imag_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_mul_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier restarted while busy");

    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy together");

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_stat.busy || div_stat.busy) |-> !s_tready)
        else $error("input ready while an item is in work");
`endif

endmodule
